[src/euv_pkg.sv]
// shared types and constants for the multiturn encoder tracker
// no dependencies; compiled first
package euv_pkg;

  localparam int RAW_W    = 16;
  localparam int ROT_W    = 32;
  localparam int VEL_W    = 32;
  localparam int THRESH_W = 14;
  localparam int MUL_W    = 20;
  localparam int QCNT_W   = 5;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd13107;
  localparam logic [MUL_W-1:0]    US_PER_S     = 20'd1000000;
  localparam logic [VEL_W-1:0]    VEL_POS_LIM  = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0]    VEL_NEG_LIM  = 32'h8000_0000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             err;
    logic [VEL_W-1:0] vel;
  } vel_res_t;

endpackage

[src/euv_in_if.sv]
// input channel: angle samples and velocity queries
// depends on euv_pkg
interface euv_in_if #(parameter int TIME_BITS = 48) ();
  import euv_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [RAW_W-1:0]     raw_word;
  logic [TIME_BITS-1:0] timestamp_us;

  modport source(output valid, op, raw_word, timestamp_us, input ready);
  modport sink(input valid, op, raw_word, timestamp_us, output ready);
endinterface

[src/euv_out_if.sv]
// result channel: angle, turn count, velocity and error flag
// depends on euv_pkg
interface euv_out_if #(parameter int ANGLE_BITS = 14) ();
  import euv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_counts;
  logic [ROT_W-1:0]      turn_count;
  logic [VEL_W-1:0]      velocity_cps;
  logic                  time_error;

  modport source(output valid, angle_counts, turn_count, velocity_cps, time_error,
                 input ready);
  modport sink(input valid, angle_counts, turn_count, velocity_cps, time_error,
               output ready);
endinterface

[src/euv_alu.sv]
// shared add/subtract unit used by the velocity sequencer
// no dependencies
module euv_alu #(
  parameter int W = 66
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         cout
);

  logic [W:0] full;

  // cout set on subtract means a >= b
  assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign sum  = full[W-1:0];
  assign cout = full[W];

endmodule

[src/euv_vel.sv]
// velocity sequencer: delta, shift-add multiply by 1e6, restoring divide
// depends on euv_pkg and euv_alu
module euv_vel #(
  parameter int ANGLE_BITS = 14,
  parameter int TIME_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          ack,
  input  logic [euv_pkg::ROT_W-1:0]     rot,
  input  logic [euv_pkg::ROT_W-1:0]     snap_rot,
  input  logic [ANGLE_BITS-1:0]         angle,
  input  logic [ANGLE_BITS-1:0]         snap_angle,
  input  logic [TIME_BITS-1:0]          ts,
  input  logic [TIME_BITS-1:0]          snap_ts,
  output euv_pkg::vel_res_t             res
);
  import euv_pkg::*;

  localparam int DW = ANGLE_BITS + ROT_W + 1;
  localparam int MW = ANGLE_BITS + ROT_W;
  localparam int NW = MW + MUL_W;
  localparam int UW = (NW > TIME_BITS + 1) ? NW : TIME_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_DELTA, S_TIME, S_ABS, S_MUL, S_CMP, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t               state_r;
  logic [QCNT_W-1:0]    cnt_r;
  logic [ROT_W-1:0]     drot_r;
  logic [DW-1:0]        delta_r;
  logic [MW-1:0]        mag_r;
  logic [TIME_BITS-1:0] den_r;
  logic [NW-1:0]        acc_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [VEL_W-1:0]     q_r;
  logic                 sat_r;
  logic                 err_r;
  logic [VEL_W-1:0]     vel_r;

  logic [UW-1:0]        alu_a;
  logic [UW-1:0]        alu_b;
  logic                 alu_sub;
  logic [UW-1:0]        alu_sum;
  logic                 alu_cout;
  logic                 neg;
  logic                 over;
  logic [VEL_W-1:0]     q_sat;

  euv_alu #(.W(UW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  assign neg   = delta_r[DW-1];
  assign over  = sat_r | (neg ? (q_r[VEL_W-1] & (|q_r[VEL_W-2:0])) : q_r[VEL_W-1]);
  assign q_sat = over ? (neg ? VEL_NEG_LIM : VEL_POS_LIM) : q_r;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_ROT: begin
        alu_a = UW'(rot);
        alu_b = UW'(snap_rot);
      end
      S_DELTA: begin
        // turn difference sign-extended and placed above the angle bits
        alu_a = UW'({drot_r[ROT_W-1], drot_r, angle});
        alu_b = UW'(snap_angle);
      end
      S_TIME: begin
        alu_a = UW'(ts);
        alu_b = UW'(snap_ts);
      end
      S_ABS: begin
        alu_b = UW'(delta_r);
      end
      S_MUL: begin
        alu_a   = UW'({acc_r[NW-2:0], 1'b0});
        alu_b   = US_PER_S[cnt_r] ? UW'(mag_r) : '0;
        alu_sub = 1'b0;
      end
      S_CMP: begin
        // quotient overflows 32 bits when the upper numerator reaches the divisor
        alu_a = UW'(acc_r[NW-1:VEL_W]);
        alu_b = UW'(den_r);
      end
      S_DIV: begin
        alu_a = UW'({rem_r, acc_r[VEL_W-1]});
        alu_b = UW'(den_r);
      end
      S_FIN: begin
        alu_b   = UW'(q_sat);
        alu_sub = neg;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          drot_r  <= alu_sum[ROT_W-1:0];
          state_r <= S_DELTA;
        end
        S_DELTA: begin
          delta_r <= alu_sum[DW-1:0];
          state_r <= S_TIME;
        end
        S_TIME: begin
          den_r   <= alu_sum[TIME_BITS-1:0];
          state_r <= S_ABS;
        end
        S_ABS: begin
          mag_r <= neg ? alu_sum[MW-1:0] : delta_r[MW-1:0];
          acc_r <= '0;
          cnt_r <= QCNT_W'(MUL_W - 1);
          if (den_r == '0) begin
            err_r   <= 1'b1;
            vel_r   <= '0;
            state_r <= S_DONE;
          end else begin
            err_r   <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r <= alu_sum[NW-1:0];
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          sat_r   <= alu_cout;
          rem_r   <= alu_a[TIME_BITS-1:0];
          cnt_r   <= QCNT_W'(VEL_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= alu_cout ? alu_sum[TIME_BITS-1:0] : alu_a[TIME_BITS-1:0];
          q_r   <= {q_r[VEL_W-2:0], alu_cout};
          acc_r <= {acc_r[NW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          vel_r   <= alu_sum[VEL_W-1:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (ack) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid = (state_r == S_DONE);
  assign res.err   = err_r;
  assign res.vel   = vel_r;

endmodule

[src/encoder_angle_unwrap_velocity.sv]
// Multiturn tracker for an absolute angle sensor with velocity between queries.
// An angle sample is written into the output register at the edge that accepts it.
// The input is ready again as soon as that register is free or being read. A
// velocity query runs on a single shared adder in euv_vel: four setup steps (turn
// difference, count difference, elapsed time, magnitude), a 20-bit shift-add scale
// by 1e6, one overflow compare, a 32-bit restoring divide and one sign step. Its
// item lands in the output register after the sign step once that register is
// free, so an output stall delays it. A query with zero elapsed time goes from
// the magnitude step straight to the result. No other item is taken while a query
// is in flight. Depends on euv_pkg, euv_in_if, euv_out_if, euv_vel.
module encoder_angle_unwrap_velocity #(
  parameter int ANGLE_BITS = 14,
  parameter int TIME_BITS  = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  euv_in_if.sink                         in_ch,
  euv_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [euv_pkg::THRESH_W-1:0]   cfg_wdata
);
  import euv_pkg::*;

  localparam int RAW_EXT_W = (ANGLE_BITS > RAW_W) ? ANGLE_BITS : RAW_W;
  localparam int CMP_W     = (ANGLE_BITS > THRESH_W) ? ANGLE_BITS : THRESH_W;

  typedef enum logic {ST_IDLE, ST_BUSY} state_t;

  state_t                state_r;
  logic [THRESH_W-1:0]   thresh_r;
  logic [ANGLE_BITS-1:0] last_angle_r;
  logic [ROT_W-1:0]      rot_r;
  logic [TIME_BITS-1:0]  last_ts_r;
  logic [ANGLE_BITS-1:0] snap_angle_r;
  logic [ROT_W-1:0]      snap_rot_r;
  logic [TIME_BITS-1:0]  snap_ts_r;
  logic                  out_valid_r;
  logic [ANGLE_BITS-1:0] out_angle_r;
  logic [ROT_W-1:0]      out_rot_r;
  logic [VEL_W-1:0]      out_vel_r;
  logic                  out_err_r;

  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic                  start;
  logic                  ack;
  vel_res_t              res;
  logic [RAW_EXT_W-1:0]  raw_ext;
  logic [ANGLE_BITS-1:0] new_angle;
  logic [ANGLE_BITS:0]   diff;
  logic [ANGLE_BITS:0]   jump_full;
  logic                  wrap;
  logic [ROT_W-1:0]      rot_nxt;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign start        = in_fire && (in_ch.op == OP_QUERY);
  assign ack          = res.valid && out_free;
  // a sample or a finished query fills the output register
  assign out_load     = (in_fire && (in_ch.op == OP_SAMPLE)) || ack;

  assign raw_ext   = RAW_EXT_W'(in_ch.raw_word);
  assign new_angle = raw_ext[ANGLE_BITS-1:0];
  assign diff      = {1'b0, new_angle} - {1'b0, last_angle_r};
  assign jump_full = diff[ANGLE_BITS] ? (~diff + 1'b1) : diff;
  assign wrap      = CMP_W'(jump_full[ANGLE_BITS-1:0]) > CMP_W'(thresh_r);

  // forward jump past the threshold means the angle wrapped backward
  always_comb begin
    rot_nxt = rot_r;
    if (wrap) begin
      rot_nxt = diff[ANGLE_BITS] ? rot_r + 1'b1 : rot_r - 1'b1;
    end
  end

  euv_vel #(
    .ANGLE_BITS (ANGLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_vel (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .ack        (ack),
    .rot        (rot_r),
    .snap_rot   (snap_rot_r),
    .angle      (last_angle_r),
    .snap_angle (snap_angle_r),
    .ts         (last_ts_r),
    .snap_ts    (snap_ts_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thresh_r     <= THRESH_RESET;
      last_angle_r <= '0;
      rot_r        <= '0;
      last_ts_r    <= '0;
      snap_angle_r <= '0;
      snap_rot_r   <= '0;
      snap_ts_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.op == OP_SAMPLE) begin
              last_angle_r <= new_angle;
              rot_r        <= rot_nxt;
              last_ts_r    <= in_ch.timestamp_us;
              out_angle_r  <= new_angle;
              out_rot_r    <= rot_nxt;
              out_vel_r    <= '0;
              out_err_r    <= 1'b0;
            end else begin
              state_r <= ST_BUSY;
            end
          end
        end
        ST_BUSY: begin
          if (ack) begin
            out_angle_r  <= last_angle_r;
            out_rot_r    <= rot_r;
            out_vel_r    <= res.vel;
            out_err_r    <= res.err;
            snap_angle_r <= last_angle_r;
            snap_rot_r   <= rot_r;
            snap_ts_r    <= last_ts_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.angle_counts = out_angle_r;
  assign out_ch.turn_count   = out_rot_r;
  assign out_ch.velocity_cps = out_vel_r;
  assign out_ch.time_error   = out_err_r;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for encoder_angle_unwrap_velocity: a queue-fed driver,
// a stalling result sink and a scoreboard with its own turn/velocity tracker.
// Depends on euv_pkg, euv_in_if, euv_out_if and the block under test.
module tb;
  import euv_pkg::*;

  localparam int ANGLE_BITS   = 14;
  localparam int TIME_BITS    = 48;
  localparam int DRAIN_CYCLES = 70;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 190;

  typedef struct {
    logic                 op;
    logic [RAW_W-1:0]     raw_word;
    logic [TIME_BITS-1:0] timestamp_us;
  } enc_item_t;

  typedef struct {
    logic [ANGLE_BITS-1:0] angle;
    logic [ROT_W-1:0]      turns;
    logic [VEL_W-1:0]      velocity;
    logic                  time_err;
  } enc_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [THRESH_W-1:0] cfg_wdata;

  euv_in_if  #(.TIME_BITS(TIME_BITS))   in_ch ();
  euv_out_if #(.ANGLE_BITS(ANGLE_BITS)) out_ch ();

  encoder_angle_unwrap_velocity #(.ANGLE_BITS(ANGLE_BITS), .TIME_BITS(TIME_BITS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  enc_item_t   item_backlog[$];
  enc_result_t predicted_outs[$];
  int          items_queued = 0;
  int          items_taken  = 0;
  int          fail_count   = 0;
  int          cycle_count  = 0;
  int          send_gap     = 0;
  int          recv_stall   = 0;
  logic        in_taken     = 1'b0;
  logic        no_idle      = 1'b0;

  // tracker state, mirrors the block
  logic [THRESH_W-1:0]   trk_thresh     = THRESH_RESET;
  logic [ANGLE_BITS-1:0] trk_angle      = '0;
  logic [ROT_W-1:0]      trk_turns      = '0;
  logic [TIME_BITS-1:0]  trk_time       = '0;
  logic [ANGLE_BITS-1:0] snap_angle_q   = '0;
  logic [ROT_W-1:0]      snap_turns_q   = '0;
  logic [TIME_BITS-1:0]  snap_time_q    = '0;

  // motion generator state
  logic [ANGLE_BITS-1:0] mot_angle = '0;
  logic [TIME_BITS-1:0]  mot_time  = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(90, 20);
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_ts();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_BITS-1:0];
  endfunction

  function automatic enc_result_t track_encoder(enc_item_t it);
    enc_result_t           r;
    logic [ANGLE_BITS-1:0] ang;
    int                    jump;
    logic [TIME_BITS-1:0]  elapsed;
    logic signed [31:0]    dturn;
    longint                delta;
    logic [63:0]           mag;
    logic [127:0]          quo;
    logic [VEL_W-1:0]      lim;
    r.velocity = '0;
    r.time_err = 1'b0;
    if (it.op == OP_SAMPLE) begin
      ang  = it.raw_word[ANGLE_BITS-1:0];
      jump = int'(ang) - int'(trk_angle);
      // strictly larger than threshold; positive jump means a turn backward
      if ((jump < 0 ? -jump : jump) > int'(trk_thresh))
        trk_turns = (jump > 0) ? trk_turns - 1 : trk_turns + 1;
      trk_angle = ang;
      trk_time  = it.timestamp_us;
    end else begin
      elapsed = trk_time - snap_time_q;
      if (elapsed == '0) begin
        r.time_err = 1'b1;
      end else begin
        dturn = trk_turns - snap_turns_q;
        delta = longint'(dturn) * (longint'(1) << ANGLE_BITS)
              + (longint'(trk_angle) - longint'(snap_angle_q));
        mag   = (delta < 0) ? -delta : delta;
        quo   = ({64'd0, mag} * 128'd1000000) / {80'd0, elapsed};
        lim   = (delta < 0) ? VEL_NEG_LIM : VEL_POS_LIM;
        if (quo > {96'd0, lim}) quo = {96'd0, lim};
        r.velocity = (delta < 0) ? -quo[VEL_W-1:0] : quo[VEL_W-1:0];
      end
      snap_angle_q = trk_angle;
      snap_turns_q = trk_turns;
      snap_time_q  = trk_time;
    end
    r.angle = trk_angle;
    r.turns = trk_turns;
    return r;
  endfunction

  function automatic void push_item(logic op, logic [RAW_W-1:0] raw,
                                    logic [TIME_BITS-1:0] ts);
    enc_item_t it;
    it.op           = op;
    it.raw_word     = raw;
    it.timestamp_us = ts;
    item_backlog.push_back(it);
    items_queued++;
  endfunction

  // a rotating shaft: steady direction, occasional reversal, then a query
  function automatic int queue_motion();
    int               n_samp, span, dir, dt_max, step, k, pushed;
    logic [RAW_W-1:0] raw;
    n_samp = $urandom_range(12, 2);
    case ($urandom_range(7))
      0, 1, 2: span = 200;
      3, 4, 5: span = 3000;
      6:       span = 8191;
      default: span = 16383;
    endcase
    case ($urandom_range(5))
      0, 1, 2: dt_max = 50;
      3, 4:    dt_max = 2000;
      default: dt_max = 200000;
    endcase
    dir    = $urandom_range(1) ? 1 : -1;
    pushed = 0;
    for (k = 0; k < n_samp; k++) begin
      step = dir * int'($urandom_range(span));
      if ($urandom_range(7) == 0) step = -step;
      mot_angle = ANGLE_BITS'(int'(mot_angle) + step);
      mot_time  = mot_time + TIME_BITS'($urandom_range(dt_max, 1));
      raw       = RAW_W'($urandom);
      raw[ANGLE_BITS-1:0] = mot_angle;
      push_item(OP_SAMPLE, raw, mot_time);
      pushed++;
    end
    push_item(OP_QUERY, RAW_W'($urandom), rand_ts());
    pushed++;
    if ($urandom_range(9) == 0) begin
      push_item(OP_QUERY, RAW_W'($urandom), rand_ts());
      pushed++;
    end
    return pushed;
  endfunction

  function automatic int queue_noise();
    int n, k;
    n = $urandom_range(6, 1);
    for (k = 0; k < n; k++)
      push_item($urandom_range(1) ? OP_QUERY : OP_SAMPLE, RAW_W'($urandom), rand_ts());
    return n;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (items_taken != items_queued || predicted_outs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THRESH_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin : item_driver
    enc_item_t nxt;
    logic      drive_new;
    drive_new = 1'b0;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (item_backlog.size() > 0) begin
        nxt       = item_backlog.pop_front();
        drive_new = 1'b1;
        send_gap  = pick_gap();
      end
      if (drive_new) begin
        in_ch.op           <= nxt.op;
        in_ch.raw_word     <= nxt.raw_word;
        in_ch.timestamp_us <= nxt.timestamp_us;
      end
      in_ch.valid <= drive_new;
    end
  end

  // result sink with random back-pressure
  always @(negedge clk) begin : result_sink
    if (rst_n) begin
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(3) == 0) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    enc_result_t want;
    enc_item_t   got_in;
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_we) trk_thresh = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_outs.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = predicted_outs.pop_front();
          if (out_ch.angle_counts !== want.angle) begin
            $error("angle_counts: expected %0d, got %0d", want.angle, out_ch.angle_counts);
            fail_count++;
          end
          if (out_ch.turn_count !== want.turns) begin
            $error("turn_count: expected %0d, got %0d",
                   $signed(want.turns), $signed(out_ch.turn_count));
            fail_count++;
          end
          if (out_ch.velocity_cps !== want.velocity) begin
            $error("velocity_cps: expected %0d, got %0d",
                   $signed(want.velocity), $signed(out_ch.velocity_cps));
            fail_count++;
          end
          if (out_ch.time_error !== want.time_err) begin
            $error("time_error: expected %0b, got %0b", want.time_err, out_ch.time_error);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got_in.op           = in_ch.op;
        got_in.raw_word     = in_ch.raw_word;
        got_in.timestamp_us = in_ch.timestamp_us;
        predicted_outs.push_back(track_encoder(got_in));
        items_taken++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("encoder_angle_unwrap_velocity regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int                  ph, n;
    logic [THRESH_W-1:0] th;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_SAMPLE;
    in_ch.raw_word     = '0;
    in_ch.timestamp_us = '0;
    out_ch.ready       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset threshold: zero elapsed, wrap edges, saturation, backward time
    push_item(OP_QUERY,  16'h0000, 48'd0);
    push_item(OP_SAMPLE, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    push_item(OP_SAMPLE, 16'h0000, 48'd1);
    push_item(OP_SAMPLE, 16'hF333, 48'd2);   // jump equal to threshold
    push_item(OP_SAMPLE, 16'h0000, 48'd5);
    push_item(OP_SAMPLE, 16'h3334, 48'd10);  // one past threshold
    push_item(OP_QUERY,  16'hFFFF, 48'hFFFF_FFFF_FFFF);
    push_item(OP_SAMPLE, 16'h0000, 48'd9);   // time goes backward
    push_item(OP_QUERY,  16'h0000, 48'd0);
    push_item(OP_QUERY,  16'h0000, 48'd0);
    push_item(OP_SAMPLE, 16'h2000, 48'd10);  // huge positive rate
    push_item(OP_QUERY,  16'h0000, 48'd0);
    push_item(OP_SAMPLE, 16'h0000, 48'd11);  // huge negative rate
    push_item(OP_QUERY,  16'h0000, 48'd0);
    push_item(OP_SAMPLE, 16'h4001, 48'd10);  // elapsed wraps to all ones
    push_item(OP_QUERY,  16'h0000, 48'd0);
    wait_idle();
    write_threshold('0);
    push_item(OP_SAMPLE, 16'h0001, 48'd20);
    push_item(OP_SAMPLE, 16'h8002, 48'd30);
    push_item(OP_SAMPLE, 16'h0000, 48'd40);
    push_item(OP_QUERY,  16'h0000, 48'd0);
    wait_idle();
    write_threshold(14'h3FFF);
    push_item(OP_SAMPLE, 16'h3FFF, 48'd50);
    push_item(OP_SAMPLE, 16'hC000, 48'd60);
    push_item(OP_QUERY,  16'h0000, 48'd0);

    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0:       th = THRESH_RESET;
        2:       th = '0;
        4:       th = 14'h3FFF;
        default: th = THRESH_W'($urandom_range(16383));
      endcase
      write_threshold(th);
      no_idle = (ph == 3);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) n += queue_motion();
        else n += queue_noise();
      end
    end
    wait_idle();
    if (fail_count == 0)
      $display("encoder_angle_unwrap_velocity regression: pass");
    else
      $display("encoder_angle_unwrap_velocity regression: fail");
    $finish;
  end

endmodule

[filelist.f]
src/euv_pkg.sv
src/euv_in_if.sv
src/euv_out_if.sv
src/euv_alu.sv
src/euv_vel.sv
src/encoder_angle_unwrap_velocity.sv
dv/tb.sv
